@@ rtl/ring_buffer_deque_macros.svh @@
// assertion macros for the ring buffer deque
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// checked at every edge outside reset
`define RBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ring buffer deque check failed");

// checked at every edge, reset included
`define RBD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ring buffer deque reset check failed");

`endif

@@ rtl/rbd_pkg.sv @@
package rbd_pkg;

   localparam int DATA_W        = 32;
   localparam int OPC_W         = 4;
   localparam int CNT_W         = 7;
   localparam int POS_W         = 10;
   localparam int LEVEL_W       = 11;
   localparam int DEPTH_DEF     = 1024;
   localparam int MAX_BURST_DEF = 64;
   localparam int CAP_RESET     = 1024;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH_HEAD = 4'd0,
      OP_PUSH_TAIL = 4'd1,
      OP_POP_HEAD  = 4'd2,
      OP_POP_TAIL  = 4'd3,
      OP_PEEK_HEAD = 4'd4,
      OP_PEEK_TAIL = 4'd5,
      OP_GET_HEAD  = 4'd6,
      OP_GET_TAIL  = 4'd7,
      OP_DROP_HEAD = 4'd8,
      OP_DROP_TAIL = 4'd9,
      OP_CLEAR     = 4'd10
   } opcode_type;

endpackage

@@ rtl/rbd_if.sv @@
interface rbd_req_if;
   import rbd_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPC_W-1:0]    opcode;
   logic [DATA_W-1:0]   data_in;
   logic [CNT_W-1:0]    count;
   logic [POS_W-1:0]    position;
   modport source(output valid, output opcode, output data_in, output count,
                  output position, input ready);
   modport sink(input valid, input opcode, input data_in, input count,
                input position, output ready);
endinterface

interface rbd_rsp_if;
   import rbd_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_out;
   logic                ok;
   logic [CNT_W-1:0]    done_count;
   logic [LEVEL_W-1:0]  level;
   logic                last;
   modport source(output valid, output data_out, output ok, output done_count,
                  output level, output last, input ready);
   modport sink(input valid, input data_out, input ok, input done_count,
                input level, input last, output ready);
endinterface

interface rbd_csr_if;
   import rbd_pkg::*;
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  capacity;
   modport source(output valid, output capacity, input ready);
   modport sink(input valid, input capacity, output ready);
endinterface

@@ rtl/rbd_ram.sv @@
module rbd_ram #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [rbd_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [rbd_pkg::DATA_W-1:0] rd_data
);
   import rbd_pkg::*;

   logic [DATA_W-1:0] word_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= word_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ring_buffer_deque.sv @@
// Double-ended ring buffer of 32-bit words held in one synchronous RAM.
// req_ch carries one command item: push or pop at either end, peek, indexed
// get, drop, clear. rsp_ch returns the results: one item per command, or one
// item per word for a pop or peek burst, head-side word first, last set on the
// final one. csr_ch writes the ring capacity (clamped to 1..DEPTH) and empties
// the ring; it is taken only while no command is in progress.
// Push, drop, clear, refused or empty commands: the result is registered at
// the accepting edge, so one command per cycle while rsp_ch is taken.
// Indexed get: one RAM read; the word passes the RAM read register, then the
// output register. Pop or peek of n words: n RAM reads on the single read
// port, back to back while rsp_ch is taken. Neither takes a new command until
// its last result is in the output register.
// Results sit in an output register; when the receiver stalls it holds and
// req_ch.ready stays low until the pending result is taken.
// Reset empties the ring, sets capacity 1024 (or DEPTH if smaller) and drops
// any pending result. Words in the RAM are not cleared.
module ring_buffer_deque #(
   parameter int DEPTH     = rbd_pkg::DEPTH_DEF,
   parameter int MAX_BURST = rbd_pkg::MAX_BURST_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rbd_csr_if.sink    csr_ch,
   rbd_req_if.sink    req_ch,
   rbd_rsp_if.source  rsp_ch
);
   import rbd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int SW = LEVEL_W + 1;
   localparam logic [LEVEL_W-1:0] CAP_INIT =
      LEVEL_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

   typedef enum logic {S_IDLE, S_EMIT} state_type;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   cap_ff, cap_in;
   logic [LEVEL_W-1:0]   head_ff, head_in;
   logic [LEVEL_W-1:0]   tail_ff, tail_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]    out_data_ff, out_data_in;
   logic                 out_ok_ff, out_ok_in;
   logic [CNT_W-1:0]     out_done_ff, out_done_in;
   logic [LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic                 out_last_ff, out_last_in;

   logic                 ram_we, ram_re;
   logic [LEVEL_W-1:0]   ram_wslot, ram_rslot;
   logic [DATA_W-1:0]    ram_rdata;

   logic                 out_free, req_acc, csr_acc;
   opcode_type           op;
   logic [LEVEL_W-1:0]   lvl_cnt, cap_wr;
   logic [CNT_W-1:0]     burst_n;
   logic                 full, pos_ok;
   logic [LEVEL_W-1:0]   head_dec, tail_inc, head_adv, tail_back;
   logic [LEVEL_W-1:0]   get_slot, burst_start;

   function automatic logic [LEVEL_W-1:0] ring_add(
      input logic [LEVEL_W-1:0] a,
      input logic [SW-1:0]      b,
      input logic [LEVEL_W-1:0] c
   );
      logic [SW-1:0] s;
      s = {1'b0, a} + b;
      if (s >= {1'b0, c}) begin
         s = s - {1'b0, c};
      end
      return s[LEVEL_W-1:0];
   endfunction

   rbd_ram #(.DEPTH(DEPTH)) u_rbd_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(ram_wslot)),
      .wr_data (req_ch.data_in),
      .rd_en   (ram_re),
      .rd_addr (AW'(ram_rslot)),
      .rd_data (ram_rdata)
   );

   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign csr_ch.ready  = (state_ff == S_IDLE);
   assign req_ch.ready  = (state_ff == S_IDLE) && out_free && !csr_ch.valid;
   assign csr_acc       = csr_ch.valid && csr_ch.ready;
   assign req_acc       = req_ch.valid && req_ch.ready;
   assign op            = opcode_type'(req_ch.opcode);

   assign cap_wr = (csr_ch.capacity == '0) ? LEVEL_W'(1) :
                   (32'(csr_ch.capacity) > DEPTH) ? LEVEL_W'(DEPTH) :
                   csr_ch.capacity;

   assign lvl_cnt = (LEVEL_W'(req_ch.count) < level_ff) ? LEVEL_W'(req_ch.count)
                                                        : level_ff;
   assign burst_n = (lvl_cnt > LEVEL_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                    : CNT_W'(lvl_cnt);
   assign full    = (level_ff >= cap_ff);
   assign pos_ok  = (LEVEL_W'(req_ch.position) < level_ff);

   assign head_dec  = (head_ff == '0) ? (cap_ff - LEVEL_W'(1)) : (head_ff - LEVEL_W'(1));
   assign tail_inc  = ring_add(tail_ff, SW'(1), cap_ff);
   assign head_adv  = ring_add(head_ff, SW'(burst_n), cap_ff);
   assign tail_back = ring_add(tail_ff, {1'b0, cap_ff} - SW'(burst_n), cap_ff);
   assign get_slot  = (op == OP_GET_HEAD)
                    ? ring_add(head_ff, SW'(req_ch.position), cap_ff)
                    : ring_add(tail_ff, {1'b0, cap_ff} - SW'(1) - SW'(req_ch.position),
                               cap_ff);
   assign burst_start = (op == OP_POP_HEAD || op == OP_PEEK_HEAD) ? head_ff : tail_back;

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      remain_in    = remain_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;
      out_ok_in    = out_ok_ff;
      out_done_in  = out_done_ff;
      out_level_in = out_level_ff;
      out_last_in  = out_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wslot    = '0;
      ram_rslot    = '0;

      unique case (state_ff)
         S_IDLE: begin
            priority if (csr_acc) begin
               cap_in   = cap_wr;
               head_in  = '0;
               tail_in  = '0;
               level_in = '0;
            end else if (req_acc) begin
               out_valid_in = 1'b1;
               out_data_in  = '0;
               out_ok_in    = 1'b0;
               out_done_in  = '0;
               out_level_in = level_ff;
               out_last_in  = 1'b1;
               unique case (op)
                  OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                     if (!full) begin
                        ram_we       = 1'b1;
                        level_in     = level_ff + LEVEL_W'(1);
                        out_ok_in    = 1'b1;
                        out_done_in  = CNT_W'(1);
                        out_level_in = level_ff + LEVEL_W'(1);
                        if (op == OP_PUSH_HEAD) begin
                           ram_wslot = head_dec;
                           head_in   = head_dec;
                        end else begin
                           ram_wslot = tail_ff;
                           tail_in   = tail_inc;
                        end
                     end
                  end
                  OP_POP_HEAD, OP_POP_TAIL, OP_PEEK_HEAD, OP_PEEK_TAIL: begin
                     if (burst_n != '0) begin
                        out_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_rslot    = burst_start;
                        cur_in       = ring_add(burst_start, SW'(1), cap_ff);
                        remain_in    = burst_n;
                        total_in     = burst_n;
                        state_in     = S_EMIT;
                        if (op == OP_POP_HEAD) begin
                           head_in  = head_adv;
                           level_in = level_ff - LEVEL_W'(burst_n);
                        end else if (op == OP_POP_TAIL) begin
                           tail_in  = tail_back;
                           level_in = level_ff - LEVEL_W'(burst_n);
                        end
                     end
                  end
                  OP_GET_HEAD, OP_GET_TAIL: begin
                     if (pos_ok) begin
                        out_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_rslot    = get_slot;
                        remain_in    = CNT_W'(1);
                        total_in     = '0;
                        state_in     = S_EMIT;
                     end else begin
                        out_data_in = req_ch.data_in;
                     end
                  end
                  OP_DROP_HEAD, OP_DROP_TAIL: begin
                     if (burst_n != '0) begin
                        if (op == OP_DROP_HEAD) begin
                           head_in = head_adv;
                        end else begin
                           tail_in = tail_back;
                        end
                        level_in     = level_ff - LEVEL_W'(burst_n);
                        out_ok_in    = 1'b1;
                        out_done_in  = burst_n;
                        out_level_in = level_ff - LEVEL_W'(burst_n);
                     end
                  end
                  OP_CLEAR: begin
                     head_in      = '0;
                     tail_in      = '0;
                     level_in     = '0;
                     out_ok_in    = 1'b1;
                     out_level_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = ram_rdata;
               out_ok_in    = 1'b1;
               out_done_in  = total_ff;
               out_level_in = level_ff;
               out_last_in  = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_rslot = cur_ff;
                  cur_in    = ring_add(cur_ff, SW'(1), cap_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_INIT;
         head_ff      <= '0;
         tail_ff      <= '0;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff       <= cur_in;
      remain_ff    <= remain_in;
      total_ff     <= total_in;
      out_data_ff  <= out_data_in;
      out_ok_ff    <= out_ok_in;
      out_done_ff  <= out_done_in;
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.data_out   = out_data_ff;
   assign rsp_ch.ok         = out_ok_ff;
   assign rsp_ch.done_count = out_done_ff;
   assign rsp_ch.level      = out_level_ff;
   assign rsp_ch.last       = out_last_ff;

endmodule

@@ rtl/rbd_checker.sv @@
`include "ring_buffer_deque_macros.svh"

module rbd_checker #(
   parameter int DEPTH     = rbd_pkg::DEPTH_DEF,
   parameter int MAX_BURST = rbd_pkg::MAX_BURST_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rbd_pkg::DATA_W-1:0]  rsp_data_out,
   input logic                        rsp_ok,
   input logic [rbd_pkg::CNT_W-1:0]   rsp_done_count,
   input logic [rbd_pkg::LEVEL_W-1:0] rsp_level,
   input logic                        rsp_last
);
   import rbd_pkg::*;

   // stalled item holds
   `RBD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_last) && $stable(rsp_level))

   // no new item taken while a result waits
   `RBD_ASSERT(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready |-> !req_ready)

   // failed item moves nothing
   `RBD_ASSERT(a_fail_no_count, clock, reset, rsp_valid && !rsp_ok |-> rsp_done_count == '0)

   // level and count bounds
   `RBD_ASSERT(a_bounds, clock, reset, rsp_valid |-> (32'(rsp_level) <= DEPTH) && (32'(rsp_done_count) <= MAX_BURST))

   // reset drops the pending item
   `RBD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

bind ring_buffer_deque rbd_checker #(
   .DEPTH     (DEPTH),
   .MAX_BURST (MAX_BURST)
) u_rbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_data_out   (rsp_ch.data_out),
   .rsp_ok         (rsp_ch.ok),
   .rsp_done_count (rsp_ch.done_count),
   .rsp_level      (rsp_ch.level),
   .rsp_last       (rsp_ch.last)
);

@@ test/tb_ring_buffer_deque.sv @@
`timescale 1ns / 100ps

module tb_ring_buffer_deque;
   import rbd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 3;
   localparam int DRAIN_CYCLES  = 20;
   localparam logic [OPC_W-1:0] OP_UNUSED_FIRST = 4'd11;
   localparam logic [OPC_W-1:0] OP_UNUSED_LAST  = 4'd15;

   typedef struct {
      logic [DATA_W-1:0]  data_out;
      logic               ok;
      logic [CNT_W-1:0]   done_count;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } deque_result_type;

   class deque_tracker;
      logic [DATA_W-1:0]  words [DEPTH_DEF];
      int unsigned        head_slot;
      int unsigned        tail_slot;
      int unsigned        fill;
      logic [LEVEL_W-1:0] capacity_reg;
      deque_result_type   expected_results [$];
      int                 errors;

      function new();
         capacity_reg = LEVEL_W'(CAP_RESET);
         head_slot = 0;
         tail_slot = 0;
         fill = 0;
         errors = 0;
      endfunction

      function void set_capacity(logic [LEVEL_W-1:0] value);
         capacity_reg = value;
         head_slot = 0;
         tail_slot = 0;
         fill = 0;
      endfunction

      function int unsigned ring_size();
         if (capacity_reg == 0) return 1;
         if (capacity_reg > DEPTH_DEF) return DEPTH_DEF;
         return capacity_reg;
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      function void queue_result(logic [DATA_W-1:0] data, logic ok, int unsigned done,
                                 logic last);
         deque_result_type res;
         res.data_out = data;
         res.ok = ok;
         res.done_count = done[CNT_W-1:0];
         res.level = fill[LEVEL_W-1:0];
         res.last = last;
         expected_results.push_back(res);
      endfunction

      function void note_command(logic [OPC_W-1:0] opc, logic [DATA_W-1:0] din,
                                 logic [CNT_W-1:0] cnt, logic [POS_W-1:0] pos);
         int unsigned cap;
         int unsigned n;
         int unsigned first;
         int unsigned slot;
         cap = ring_size();
         head_slot = head_slot % cap;
         tail_slot = tail_slot % cap;
         if (fill > cap) fill = cap;
         n = cnt;
         if (n > fill) n = fill;
         if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
         case (opc)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
               if (fill >= cap) begin
                  queue_result('0, 1'b0, 0, 1'b1);
               end else begin
                  if (opc == OP_PUSH_HEAD) begin
                     head_slot = (head_slot + cap - 1) % cap;
                     words[head_slot] = din;
                  end else begin
                     words[tail_slot] = din;
                     tail_slot = (tail_slot + 1) % cap;
                  end
                  fill++;
                  queue_result('0, 1'b1, 1, 1'b1);
               end
            end
            OP_POP_HEAD, OP_POP_TAIL, OP_PEEK_HEAD, OP_PEEK_TAIL: begin
               if (n == 0) begin
                  queue_result('0, 1'b0, 0, 1'b1);
               end else begin
                  if (opc == OP_POP_HEAD || opc == OP_PEEK_HEAD) first = head_slot;
                  else first = (tail_slot + cap - n) % cap;
                  if (opc == OP_POP_HEAD) begin
                     head_slot = (head_slot + n) % cap;
                     fill -= n;
                  end else if (opc == OP_POP_TAIL) begin
                     tail_slot = first;
                     fill -= n;
                  end
                  for (int unsigned i = 0; i < n; i++)
                     queue_result(words[(first + i) % cap], 1'b1, n, i + 1 == n);
               end
            end
            OP_GET_HEAD, OP_GET_TAIL: begin
               if (pos >= fill) begin
                  queue_result(din, 1'b0, 0, 1'b1);
               end else begin
                  if (opc == OP_GET_HEAD) slot = (head_slot + pos) % cap;
                  else slot = (tail_slot + cap - 1 - pos) % cap;
                  queue_result(words[slot], 1'b1, 0, 1'b1);
               end
            end
            OP_DROP_HEAD, OP_DROP_TAIL: begin
               if (n > 0) begin
                  if (opc == OP_DROP_HEAD) head_slot = (head_slot + n) % cap;
                  else tail_slot = (tail_slot + cap - n) % cap;
                  fill -= n;
               end
               queue_result('0, n > 0, n, 1'b1);
            end
            OP_CLEAR: begin
               head_slot = 0;
               tail_slot = 0;
               fill = 0;
               queue_result('0, 1'b1, 0, 1'b1);
            end
            default: begin
               queue_result('0, 1'b0, 0, 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string field, logic [DATA_W-1:0] exp,
                                  logic [DATA_W-1:0] act);
         if (act !== exp) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, act);
         end
      endfunction

      function void check_result(logic [DATA_W-1:0] data_out, logic ok,
                                 logic [CNT_W-1:0] done_count, logic [LEVEL_W-1:0] level,
                                 logic last);
         deque_result_type exp;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, got data_out %0h",
                     $time, data_out);
            return;
         end
         exp = expected_results.pop_front();
         compare_field("data_out", exp.data_out, data_out);
         compare_field("ok", exp.ok, ok);
         compare_field("done_count", exp.done_count, done_count);
         compare_field("level", exp.level, level);
         compare_field("last", exp.last, last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   rsp_idle_pct;
   int   hold_requests;
   int   holds_done = 0;
   int   hold_left = 0;
   int   cycle_count = 0;

   deque_tracker tracker;

   rbd_req_if req_bus();
   rbd_rsp_if rsp_bus();
   rbd_csr_if csr_bus();

   ring_buffer_deque i_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_bus),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_result(rsp_bus.data_out, rsp_bus.ok, rsp_bus.done_count,
                              rsp_bus.level, rsp_bus.last);
   end

   task automatic send_command(logic [OPC_W-1:0] opc, logic [DATA_W-1:0] din,
                               logic [CNT_W-1:0] cnt, logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= opc;
      req_bus.data_in  <= din;
      req_bus.count    <= cnt;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_command(opc, din, cnt, pos);
      @(negedge clock);
   endtask

   task automatic send_random(int push_pct);
      logic [OPC_W-1:0]  opc;
      logic [CNT_W-1:0]  cnt;
      logic [POS_W-1:0]  pos;
      int                pick;
      pick = $urandom_range(99);
      if (pick < push_pct)
         opc = $urandom_range(1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
      else if (pick < push_pct + 3)
         opc = OPC_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      else if (pick < push_pct + 6)
         opc = OP_CLEAR;
      else
         opc = OPC_W'($urandom_range(OP_DROP_TAIL, OP_POP_HEAD));
      cnt = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(127, 0))
                                     : CNT_W'($urandom_range(6, 0));
      if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(1023, 0));
      else pos = POS_W'($urandom_range(tracker.fill, 0));
      send_command(opc, $urandom(), cnt, pos);
   endtask

   task automatic write_capacity(logic [LEVEL_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_bus.valid    <= 1'b1;
      csr_bus.capacity <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_capacity(value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [LEVEL_W-1:0] cap, int items, int push_pct);
      write_capacity(cap);
      repeat (items) send_random(push_pct);
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      send_idle_pct = 25;
      rsp_idle_pct = 69;
      hold_requests = 0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PUSH_HEAD;
      req_bus.data_in = '0;
      req_bus.count = '0;
      req_bus.position = '0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity, empty ring cases and head wrap
      send_command(OP_POP_HEAD, 32'h0, 7'd5, 10'd0);
      send_command(OP_PEEK_TAIL, 32'h0, 7'd127, 10'd0);
      send_command(OP_GET_HEAD, 32'hdeadbeef, 7'd0, 10'd0);
      send_command(OP_DROP_TAIL, 32'h0, 7'd64, 10'd0);
      send_command(OP_PUSH_TAIL, 32'h0, 7'd0, 10'd0);
      send_command(OP_PUSH_TAIL, 32'hffffffff, 7'd0, 10'd0);
      send_command(OP_PUSH_HEAD, 32'h12345678, 7'd0, 10'd0);
      send_command(OP_GET_TAIL, 32'h0, 7'd0, 10'd0);
      send_command(OP_GET_HEAD, 32'hcafef00d, 7'd0, 10'd1023);
      send_command(OP_PEEK_TAIL, 32'h0, 7'd127, 10'd0);
      send_command(OP_UNUSED_LAST, 32'hffffffff, 7'd127, 10'd1023);

      // tiny ring: full pushes, clipping, drops and clear
      write_capacity(11'd3);
      send_command(OP_PUSH_HEAD, 32'ha5a5a5a5, 7'd0, 10'd0);
      send_command(OP_PUSH_TAIL, 32'h5a5a5a5a, 7'd0, 10'd0);
      send_command(OP_PUSH_HEAD, 32'h00000001, 7'd0, 10'd0);
      send_command(OP_PUSH_TAIL, 32'h80000000, 7'd0, 10'd0);
      send_command(OP_PUSH_HEAD, 32'h7fffffff, 7'd0, 10'd0);
      send_command(OP_GET_HEAD, 32'h0, 7'd0, 10'd2);
      send_command(OP_GET_TAIL, 32'h0, 7'd0, 10'd2);
      send_command(OP_POP_TAIL, 32'h0, 7'd1, 10'd0);
      send_command(OP_POP_HEAD, 32'h0, 7'd64, 10'd0);
      send_command(OP_PUSH_TAIL, 32'h00000007, 7'd0, 10'd0);
      send_command(OP_DROP_HEAD, 32'h0, 7'd0, 10'd0);
      send_command(OP_DROP_HEAD, 32'h0, 7'd1, 10'd0);
      send_command(OP_PUSH_HEAD, 32'h0badc0de, 7'd0, 10'd0);
      send_command(OP_CLEAR, 32'h0, 7'd0, 10'd0);
      send_command(OP_UNUSED_FIRST, 32'h0, 7'd0, 10'd0);

      run_phase(11'd0, 20, 50);
      run_phase(11'd5, 25, 55);

      send_idle_pct = 69;
      rsp_idle_pct = 25;
      write_capacity(11'd2047);
      hold_requests <= hold_requests + 1;
      repeat (40) send_random(90);
      send_command(OP_POP_HEAD, 32'h0, 7'd127, 10'd0);
      send_command(OP_PEEK_TAIL, 32'h0, 7'd64, 10'd0);
      run_phase(11'd2, 20, 50);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(11'd1024, 25, 60);
      run_phase(11'd9, 15, 55);

      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
